/* src/tcb_pkg.sv */
// Shared types, codes and reset values of the text console buffer.
`timescale 1ns / 1ps
`default_nettype none
package tcb_pkg;

	// Default store geometry
	localparam int BUFFER_ROWS_DEF = 64;
	localparam int BUFFER_COLS_DEF = 120;

	// Input opcodes
	localparam logic [2:0] OP_PUT     = 3'd0;
	localparam logic [2:0] OP_TICK    = 3'd1;
	localparam logic [2:0] OP_CLEAR   = 3'd2;
	localparam logic [2:0] OP_READ    = 3'd3;
	localparam logic [2:0] OP_BAR_ON  = 3'd4;
	localparam logic [2:0] OP_BAR_OFF = 3'd5;

	// Output commands
	localparam logic [2:0] CMD_GLYPH   = 3'd0;
	localparam logic [2:0] CMD_BLANK   = 3'd1;
	localparam logic [2:0] CMD_REDRAW  = 3'd2;
	localparam logic [2:0] CMD_CLEAR   = 3'd3;
	localparam logic [2:0] CMD_BAR_ON  = 3'd4;
	localparam logic [2:0] CMD_BAR_OFF = 3'd5;
	localparam logic [2:0] CMD_READ    = 3'd6;

	// Control characters
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;

	// Configuration register indexes
	localparam logic [1:0] CFG_VISIBLE_COLS = 2'd0;
	localparam logic [1:0] CFG_VISIBLE_ROWS = 2'd1;
	localparam logic [1:0] CFG_BLINK_PERIOD = 2'd2;

	// Configuration reset values
	localparam logic [6:0]  VISIBLE_COLS_RST = 7'd80;
	localparam logic [6:0]  VISIBLE_ROWS_RST = 7'd48;
	localparam logic [15:0] BLINK_PERIOD_RST = 16'd3000;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] char_code;
		logic [5:0] read_row;
		logic [6:0] read_col;
	} req_t;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] cell_col;
		logic [5:0] screen_row;
		logic [7:0] glyph;
		logic [5:0] window_top;
		logic       last;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUT,
		ST_SWEEP,
		ST_READ
	} state_t;

endpackage
`default_nettype wire

/* src/text_console_buffer_top.sv */
// Text console buffer: character store, cursor, window and blink control.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ------------------------------
// request   in         start high, busy low      request (tcb_pkg::req_t)
// result    out        strobe, one cycle, no hold result  (tcb_pkg::res_t)
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Newline, backspace, tick, clear and bar on/off complete on acceptance
// (busy stays low). Read cell and printable characters raise busy: a read
// waits in ST_READ for the registered store data, and a put writes in
// ST_PUT. The first character written into a fresh row also passes through
// ST_SWEEP while that row is swept to zero through the single write port.
// Results leave through an output register the cycle after they are formed;
// a wrapped character gives redraw then glyph, apart by the sweep if any.
// Reset: no clearing pass. Each physical row has a valid flag, cleared by
// reset, clear and scroll; invalid rows read as zero. Config is always ready.
//
module text_console_buffer_top #(
	parameter int BUFFER_ROWS = tcb_pkg::BUFFER_ROWS_DEF,
	parameter int BUFFER_COLS = tcb_pkg::BUFFER_COLS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// request channel
	input  wire logic          start,
	output logic               busy,
	input  wire tcb_pkg::req_t request,
	// result channel
	output logic               strobe,
	output tcb_pkg::res_t      result,
	// configuration channel
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data
);

	localparam int ROW_W  = $clog2(BUFFER_ROWS);
	localparam int COL_W  = $clog2(BUFFER_COLS + 1);
	localparam int SWP_W  = (BUFFER_COLS > 1) ? $clog2(BUFFER_COLS) : 1;
	localparam int DEPTH  = BUFFER_ROWS * BUFFER_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = ((COL_W > 7) ? COL_W : 7) + 1;
	localparam int TOP_W  = ((ROW_W > 7) ? ROW_W : 7) + 1;

	// config registers
	logic [6:0]  vis_cols_q;
	logic [6:0]  vis_rows_q;
	logic [15:0] blink_period_q;

	// control state
	tcb_pkg::state_t  state_q, state_d;
	logic [ROW_W-1:0] row_q, row_d;       // cursor, logical buffer row
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] top_q, top_d;       // window top, logical row
	logic [ROW_W-1:0] base_q, base_d;     // ring offset: logical row 0 lives here
	logic [BUFFER_ROWS-1:0] valid_q, valid_d;
	logic [15:0]      count_q, count_d;
	logic             shown_q, shown_d;
	logic [SWP_W-1:0] sweep_q, sweep_d;

	// payload held across an item
	logic [7:0] char_q, char_d;
	logic [5:0] rd_row_q, rd_row_d;
	logic [6:0] rd_col_q, rd_col_d;
	logic       rd_ok_q, rd_ok_d;

	// output register
	logic          strobe_q;
	tcb_pkg::res_t result_q;
	logic          emit_v;
	tcb_pkg::res_t emit_res;

	// store port
	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        wdata, rdata;

	logic accept;

	// derived values
	logic [COL_W-1:0] eff_cols;
	logic [6:0]       eff_rows;
	logic [15:0]      eff_period;
	logic [ROW_W-1:0] cur_phys, rd_phys, base_inc;
	logic             cur_valid;
	logic             at_bottom;
	logic [ROW_W-1:0] nl_row, nl_top, nl_base;
	logic [5:0]       scr_now, scr_nl;
	logic             rd_in_range;
	logic             sweep_last;
	logic [15:0]      count_inc;

	function automatic logic [ROW_W-1:0] ring(input logic [ROW_W-1:0] r,
		input logic [ROW_W-1:0] b);
		logic [ROW_W:0] sum;
		sum = {1'b0, r} + {1'b0, b};
		if (sum >= (ROW_W+1)'(BUFFER_ROWS)) begin
			sum = sum - (ROW_W+1)'(BUFFER_ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
		input logic [COL_W-1:0] col);
		return ADDR_W'(prow) * ADDR_W'(BUFFER_COLS) + ADDR_W'(col);
	endfunction

	function automatic tcb_pkg::res_t make_res(input logic [2:0] cmd,
		input logic [6:0] col, input logic [5:0] srow, input logic [7:0] g,
		input logic [ROW_W-1:0] top, input logic lst);
		tcb_pkg::res_t r;
		r.command    = cmd;
		r.cell_col   = col;
		r.screen_row = srow;
		r.glyph      = g;
		r.window_top = 6'(top);
		r.last       = lst;
		return r;
	endfunction

	assign busy      = (state_q != tcb_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign strobe    = strobe_q;
	assign result    = result_q;

	// effective config: zero acts as one, width clipped to the store
	always_comb begin
		if (vis_cols_q == 7'd0) begin
			eff_cols = COL_W'(1);
		end else if (CMP_W'(vis_cols_q) > CMP_W'(BUFFER_COLS)) begin
			eff_cols = COL_W'(BUFFER_COLS);
		end else begin
			eff_cols = COL_W'(vis_cols_q);
		end
	end
	assign eff_rows   = (vis_rows_q == 7'd0) ? 7'd1 : vis_rows_q;
	assign eff_period = (blink_period_q == 16'd0) ? 16'd1 : blink_period_q;

	assign cur_phys  = ring(row_q, base_q);
	assign cur_valid = valid_q[cur_phys];
	assign base_inc  = (base_q == ROW_W'(BUFFER_ROWS - 1)) ? '0 : base_q + 1'b1;

	// newline: next row, or scroll by bumping the ring offset at the bottom
	assign at_bottom = (row_q == ROW_W'(BUFFER_ROWS - 1));
	assign nl_row    = at_bottom ? row_q : row_q + 1'b1;
	assign nl_base   = at_bottom ? base_inc : base_q;
	always_comb begin
		if (TOP_W'(nl_row) >= TOP_W'(eff_rows)) begin
			nl_top = ROW_W'(TOP_W'(nl_row) - TOP_W'(eff_rows) + TOP_W'(1));
		end else begin
			nl_top = '0;
		end
	end
	assign scr_now = 6'(row_q - top_q);
	assign scr_nl  = 6'(nl_row - nl_top);

	assign rd_in_range = (int'(request.read_row) < BUFFER_ROWS) &&
		(int'(request.read_col) < BUFFER_COLS);
	assign rd_phys = rd_in_range ? ring(ROW_W'(request.read_row), base_q) : '0;

	assign sweep_last = (sweep_q == SWP_W'(BUFFER_COLS - 1));
	assign count_inc  = count_q + 16'd1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcb_pkg::ST_IDLE: begin
				if (accept) begin
					if (request.opcode == tcb_pkg::OP_READ) begin
						state_d = tcb_pkg::ST_READ;
					end else if (request.opcode == tcb_pkg::OP_PUT &&
						request.char_code != tcb_pkg::CH_NEWLINE &&
						request.char_code != tcb_pkg::CH_BACKSPACE) begin
						state_d = tcb_pkg::ST_PUT;
					end
				end
			end
			tcb_pkg::ST_PUT: begin
				state_d = cur_valid ? tcb_pkg::ST_IDLE : tcb_pkg::ST_SWEEP;
			end
			tcb_pkg::ST_SWEEP: begin
				if (sweep_last) begin
					state_d = tcb_pkg::ST_PUT;
				end
			end
			tcb_pkg::ST_READ: begin
				state_d = tcb_pkg::ST_IDLE;
			end
			default: begin
				state_d = tcb_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath, store port and results
	always_comb begin
		row_d    = row_q;
		col_d    = col_q;
		top_d    = top_q;
		base_d   = base_q;
		valid_d  = valid_q;
		count_d  = count_q;
		shown_d  = shown_q;
		sweep_d  = sweep_q;
		char_d   = char_q;
		rd_row_d = rd_row_q;
		rd_col_d = rd_col_q;
		rd_ok_d  = rd_ok_q;
		we       = 1'b0;
		waddr    = cell_addr(cur_phys, col_q);
		wdata    = char_q;
		re       = 1'b0;
		raddr    = '0;
		emit_v   = 1'b0;
		emit_res = '0;

		unique case (state_q)
			tcb_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (request.opcode)
						tcb_pkg::OP_PUT: begin
							if (request.char_code == tcb_pkg::CH_NEWLINE) begin
								row_d  = nl_row;
								col_d  = '0;
								top_d  = nl_top;
								base_d = nl_base;
								if (at_bottom) begin
									valid_d[base_q] = 1'b0;
								end
								emit_v   = 1'b1;
								emit_res = make_res(tcb_pkg::CMD_REDRAW, 7'd0, scr_nl,
									8'd0, nl_top, 1'b1);
							end else if (request.char_code == tcb_pkg::CH_BACKSPACE) begin
								if (col_q != '0) begin
									col_d = col_q - 1'b1;
									// an invalid row already reads as zero
									we    = cur_valid;
									waddr = cell_addr(cur_phys, col_q - 1'b1);
									wdata = 8'd0;
									emit_v   = 1'b1;
									emit_res = make_res(tcb_pkg::CMD_BLANK, 7'(col_q - 1'b1),
										scr_now, 8'd0, top_q, 1'b1);
								end
							end else begin
								char_d = request.char_code;
								if (col_q >= eff_cols) begin
									// wrap before the character goes in
									row_d  = nl_row;
									col_d  = '0;
									top_d  = nl_top;
									base_d = nl_base;
									if (at_bottom) begin
										valid_d[base_q] = 1'b0;
									end
									emit_v   = 1'b1;
									emit_res = make_res(tcb_pkg::CMD_REDRAW, 7'd0, scr_nl,
										8'd0, nl_top, 1'b0);
								end
							end
						end
						tcb_pkg::OP_TICK: begin
							if (count_inc >= eff_period) begin
								count_d  = '0;
								shown_d  = !shown_q;
								emit_v   = 1'b1;
								emit_res = make_res(shown_q ? tcb_pkg::CMD_BAR_OFF :
									tcb_pkg::CMD_BAR_ON, 7'(col_q), scr_now, 8'd0, top_q,
									1'b1);
							end else begin
								count_d = count_inc;
							end
						end
						tcb_pkg::OP_CLEAR: begin
							row_d    = '0;
							col_d    = '0;
							top_d    = '0;
							base_d   = '0;
							valid_d  = '0;
							emit_v   = 1'b1;
							emit_res = make_res(tcb_pkg::CMD_CLEAR, 7'd0, 6'd0, 8'd0,
								'0, 1'b1);
						end
						tcb_pkg::OP_READ: begin
							re       = 1'b1;
							raddr    = rd_in_range ?
								cell_addr(rd_phys, COL_W'(request.read_col)) : '0;
							rd_row_d = request.read_row;
							rd_col_d = request.read_col;
							rd_ok_d  = rd_in_range && valid_q[rd_phys];
						end
						tcb_pkg::OP_BAR_ON: begin
							emit_v   = 1'b1;
							emit_res = make_res(tcb_pkg::CMD_BAR_ON, 7'(col_q), scr_now,
								8'd0, top_q, 1'b1);
						end
						tcb_pkg::OP_BAR_OFF: begin
							emit_v   = 1'b1;
							emit_res = make_res(tcb_pkg::CMD_BAR_OFF, 7'(col_q), scr_now,
								8'd0, top_q, 1'b1);
						end
						default: begin
							// unused opcodes are dropped
						end
					endcase
				end
			end
			tcb_pkg::ST_PUT: begin
				if (cur_valid) begin
					we       = 1'b1;
					waddr    = cell_addr(cur_phys, col_q);
					wdata    = char_q;
					col_d    = col_q + 1'b1;
					emit_v   = 1'b1;
					emit_res = make_res(tcb_pkg::CMD_GLYPH, 7'(col_q), scr_now, char_q,
						top_q, 1'b1);
				end else begin
					sweep_d = '0;
				end
			end
			tcb_pkg::ST_SWEEP: begin
				we    = 1'b1;
				waddr = cell_addr(cur_phys, COL_W'(sweep_q));
				wdata = 8'd0;
				if (sweep_last) begin
					valid_d[cur_phys] = 1'b1;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			tcb_pkg::ST_READ: begin
				emit_v   = 1'b1;
				emit_res = make_res(tcb_pkg::CMD_READ, rd_col_q, rd_row_q,
					rd_ok_q ? rdata : 8'd0, top_q, 1'b1);
			end
			default: begin
			end
		endcase
	end

	tcb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_cols_q     <= tcb_pkg::VISIBLE_COLS_RST;
			vis_rows_q     <= tcb_pkg::VISIBLE_ROWS_RST;
			blink_period_q <= tcb_pkg::BLINK_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tcb_pkg::CFG_VISIBLE_COLS: vis_cols_q     <= cfg_data[6:0];
				tcb_pkg::CFG_VISIBLE_ROWS: vis_rows_q     <= cfg_data[6:0];
				tcb_pkg::CFG_BLINK_PERIOD: blink_period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tcb_pkg::ST_IDLE;
			row_q    <= '0;
			col_q    <= '0;
			top_q    <= '0;
			base_q   <= '0;
			valid_q  <= '0;
			count_q  <= '0;
			shown_q  <= 1'b1;
			sweep_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			row_q    <= row_d;
			col_q    <= col_d;
			top_q    <= top_d;
			base_q   <= base_d;
			valid_q  <= valid_d;
			count_q  <= count_d;
			shown_q  <= shown_d;
			sweep_q  <= sweep_d;
			strobe_q <= emit_v;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		char_q   <= char_d;
		rd_row_q <= rd_row_d;
		rd_col_q <= rd_col_d;
		rd_ok_q  <= rd_ok_d;
		if (emit_v) begin
			result_q <= emit_res;
		end
	end

	// a redraw that precedes a glyph leaves the engine still holding the put
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !result_q.last |-> busy)
		else $error("non-final result while engine idle");

	// a row is swept only while it is marked stale
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcb_pkg::ST_SWEEP |-> !valid_q[cur_phys])
		else $error("sweeping a valid row");

	// read data phase only follows an accepted read request
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcb_pkg::ST_READ |->
			$past(start && !busy && request.opcode == tcb_pkg::OP_READ))
		else $error("read phase without read request");

	// the window never starts below the cursor
	assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= row_q)
		else $error("window top below cursor row");

endmodule
`default_nettype wire

/* src/tcb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the text console buffer: directed and random command streams.
`timescale 1ns / 1ps
module tb;

	localparam int ROWS     = tcb_pkg::BUFFER_ROWS_DEF;
	localparam int COLS     = tcb_pkg::BUFFER_COLS_DEF;
	// Quiet time before a register write: covers a row sweep plus the output stage.
	localparam int SETTLE   = 2 * COLS + 16;
	localparam int IDLE_PCT = 18;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          start     = 1'b0;
	logic          busy;
	tcb_pkg::req_t request   = '0;
	logic          strobe;
	tcb_pkg::res_t result;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [1:0]    cfg_index = tcb_pkg::CFG_VISIBLE_COLS;
	logic [15:0]   cfg_data  = '0;

	text_console_buffer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Run limit: far beyond the slowest legal run (every put sweeping a row).
	initial begin
		#4_000_000;
		$display("text_console_buffer_top test failed");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Shadow of the console: store, cursor, window, blink and registers
	// ---------------------------------------------------------------------
	logic [7:0]    shadow_cells [ROWS][COLS];
	int            cur_row, cur_col, win_top, blink_ticks;
	bit            bar_visible;
	int            vis_cols, vis_rows, blink_len;
	tcb_pkg::res_t expected_cmds [$];
	int            error_count = 0;
	bit            idle_enable = 1'b1;

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= 40)
			$display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic void wipe_cells();
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++)
				shadow_cells[r][c] = 8'd0;
	endfunction

	function automatic void shadow_reset();
		wipe_cells();
		cur_row     = 0;
		cur_col     = 0;
		win_top     = 0;
		blink_ticks = 0;
		bar_visible = 1'b1;
		vis_cols    = int'(tcb_pkg::VISIBLE_COLS_RST);
		vis_rows    = int'(tcb_pkg::VISIBLE_ROWS_RST);
		blink_len   = int'(tcb_pkg::BLINK_PERIOD_RST);
	endfunction

	// Zero width acts as one column, oversized width is clipped to the store.
	function automatic int width_used();
		int c;
		c = (vis_cols == 0) ? 1 : vis_cols;
		return (c > COLS) ? COLS : c;
	endfunction

	function automatic int screen_line();
		return (cur_row - win_top) & 63;
	endfunction

	// window_top always reflects the state after the operation
	function automatic void expect_cmd(input logic [2:0] cmd, input int col, input int row,
			input logic [7:0] g, input bit fin);
		tcb_pkg::res_t e;
		e.command    = cmd;
		e.cell_col   = 7'(col);
		e.screen_row = 6'(row);
		e.glyph      = g;
		e.window_top = 6'(win_top);
		e.last       = fin;
		expected_cmds.push_back(e);
	endfunction

	// Newline: next row, scrolling the whole store up at the bottom.
	function automatic void advance_line();
		int vr;
		vr = (vis_rows == 0) ? 1 : vis_rows;
		cur_row++;
		cur_col = 0;
		if (cur_row >= ROWS) begin
			cur_row = ROWS - 1;
			for (int r = 0; r < ROWS - 1; r++)
				for (int c = 0; c < COLS; c++)
					shadow_cells[r][c] = shadow_cells[r + 1][c];
			for (int c = 0; c < COLS; c++)
				shadow_cells[ROWS - 1][c] = 8'd0;
		end
		win_top = (cur_row >= vr) ? cur_row - vr + 1 : 0;
	endfunction

	// Work out the commands one accepted request causes and queue them.
	function automatic void predict_console(input tcb_pkg::req_t r);
		logic [7:0] g;
		case (r.opcode)
		tcb_pkg::OP_PUT: begin
			if (r.char_code == tcb_pkg::CH_NEWLINE) begin
				advance_line();
				expect_cmd(tcb_pkg::CMD_REDRAW, cur_col, screen_line(), 8'd0, 1'b1);
			end else if (r.char_code == tcb_pkg::CH_BACKSPACE) begin
				// nothing to erase at column zero
				if (cur_col != 0) begin
					cur_col--;
					if (cur_col < COLS)
						shadow_cells[cur_row][cur_col] = 8'd0;
					expect_cmd(tcb_pkg::CMD_BLANK, cur_col, screen_line(), 8'd0, 1'b1);
				end
			end else begin
				if (cur_col >= width_used()) begin
					advance_line();
					expect_cmd(tcb_pkg::CMD_REDRAW, cur_col, screen_line(), 8'd0, 1'b0);
				end
				shadow_cells[cur_row][cur_col] = r.char_code;
				expect_cmd(tcb_pkg::CMD_GLYPH, cur_col, screen_line(), r.char_code, 1'b1);
				cur_col++;
			end
		end
		tcb_pkg::OP_TICK: begin
			blink_ticks++;
			if (blink_ticks >= ((blink_len == 0) ? 1 : blink_len)) begin
				blink_ticks = 0;
				bar_visible = !bar_visible;
				expect_cmd(bar_visible ? tcb_pkg::CMD_BAR_ON : tcb_pkg::CMD_BAR_OFF,
					cur_col, screen_line(), 8'd0, 1'b1);
			end
		end
		tcb_pkg::OP_CLEAR: begin
			// blink state survives a clear
			wipe_cells();
			cur_row = 0;
			cur_col = 0;
			win_top = 0;
			expect_cmd(tcb_pkg::CMD_CLEAR, 0, 0, 8'd0, 1'b1);
		end
		tcb_pkg::OP_READ: begin
			g = (r.read_col < COLS) ? shadow_cells[r.read_row][r.read_col] : 8'd0;
			expect_cmd(tcb_pkg::CMD_READ, int'(r.read_col), int'(r.read_row), g, 1'b1);
		end
		tcb_pkg::OP_BAR_ON:
			expect_cmd(tcb_pkg::CMD_BAR_ON, cur_col, screen_line(), 8'd0, 1'b1);
		tcb_pkg::OP_BAR_OFF:
			expect_cmd(tcb_pkg::CMD_BAR_OFF, cur_col, screen_line(), 8'd0, 1'b1);
		default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Result checker: every strobe is matched against the oldest expectation
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		tcb_pkg::res_t want;
		if (arst_n && strobe) begin
			if (expected_cmds.size() == 0) begin
				report_mismatch("unexpected result, command", int'(result.command), -1);
			end else begin
				want = expected_cmds.pop_front();
				if (result.command !== want.command)
					report_mismatch("command", int'(result.command), int'(want.command));
				if (result.cell_col !== want.cell_col)
					report_mismatch("cell_col", int'(result.cell_col), int'(want.cell_col));
				if (result.screen_row !== want.screen_row)
					report_mismatch("screen_row", int'(result.screen_row),
						int'(want.screen_row));
				if (result.glyph !== want.glyph)
					report_mismatch("glyph", int'(result.glyph), int'(want.glyph));
				if (result.window_top !== want.window_top)
					report_mismatch("window_top", int'(result.window_top),
						int'(want.window_top));
				if (result.last !== want.last)
					report_mismatch("last", int'(result.last), int'(want.last));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------

	// One request: optional random gap, then hold start until taken.
	task automatic send_request(input tcb_pkg::req_t r);
		if (idle_enable) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		predict_console(r);
	endtask

	// Hold off the sender until every pending command has come back, then
	// let a possible row sweep or silent request run out.
	task automatic drain_console();
		start <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		tcb_pkg::CFG_VISIBLE_COLS: vis_cols = int'(val[6:0]);
		tcb_pkg::CFG_VISIBLE_ROWS: vis_rows = int'(val[6:0]);
		tcb_pkg::CFG_BLINK_PERIOD: blink_len = int'(val);
		default: ;
		endcase
	endtask

	// All three registers, written back to back while the console is quiet.
	task automatic set_geometry(input logic [15:0] cols, input logic [15:0] rows,
			input logic [15:0] period);
		drain_console();
		write_reg(tcb_pkg::CFG_VISIBLE_COLS, cols);
		write_reg(tcb_pkg::CFG_VISIBLE_ROWS, rows);
		write_reg(tcb_pkg::CFG_BLINK_PERIOD, period);
		cfg_valid <= 1'b0;
	endtask

	function automatic tcb_pkg::req_t make_req(input logic [2:0] op, input logic [7:0] ch,
			input logic [5:0] rr, input logic [6:0] rc);
		tcb_pkg::req_t r;
		r.opcode    = op;
		r.char_code = ch;
		r.read_row  = rr;
		r.read_col  = rc;
		return r;
	endfunction

	function automatic logic [7:0] random_glyph();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (c == tcb_pkg::CH_NEWLINE || c == tcb_pkg::CH_BACKSPACE);
		return c;
	endfunction

	// Mostly printable text with line breaks and erasures; reads aimed at
	// written cells most of the time; a little noise in the unused codes.
	function automatic tcb_pkg::req_t random_request();
		tcb_pkg::req_t r;
		int            pick;
		r.opcode    = tcb_pkg::OP_PUT;
		r.char_code = 8'($urandom);
		r.read_row  = 6'($urandom);
		r.read_col  = 7'($urandom);
		pick = $urandom_range(99);
		if (pick < 50) begin
			r.char_code = random_glyph();
		end else if (pick < 60) begin
			r.char_code = tcb_pkg::CH_NEWLINE;
		end else if (pick < 67) begin
			r.char_code = tcb_pkg::CH_BACKSPACE;
		end else if (pick < 77) begin
			r.opcode = tcb_pkg::OP_TICK;
		end else if (pick < 89) begin
			r.opcode = tcb_pkg::OP_READ;
			if ($urandom_range(3) != 0) begin
				r.read_row = 6'($urandom_range(cur_row));
				r.read_col = 7'((cur_col == 0) ? 0 : $urandom_range(cur_col - 1));
			end
		end else if (pick < 90) begin
			r.opcode = tcb_pkg::OP_CLEAR;
		end else if (pick < 94) begin
			r.opcode = tcb_pkg::OP_BAR_ON;
		end else if (pick < 98) begin
			r.opcode = tcb_pkg::OP_BAR_OFF;
		end else begin
			r.opcode = $urandom_range(1) ? 3'd7 : 3'd6;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset geometry: byte extremes, erase, reads in and out of the store,
	// silent requests, bar commands, unused opcodes and clear.
	task automatic test_reset_defaults();
		send_request(make_req(tcb_pkg::OP_READ, 8'h00, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_PUT, 8'h00, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_PUT, 8'hFF, 6'd63, 7'd127));
		send_request(make_req(tcb_pkg::OP_PUT, 8'h80, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_PUT, 8'h7F, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_PUT, 8'h55, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_PUT, 8'hAA, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_BACKSPACE, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_READ, 8'h00, 6'd0, 7'd2));
		send_request(make_req(tcb_pkg::OP_READ, 8'hFF, 6'd0, 7'd1));
		send_request(make_req(tcb_pkg::OP_READ, 8'h00, 6'd0, 7'd5));
		send_request(make_req(tcb_pkg::OP_READ, 8'h00, 6'd63, 7'd119));
		// columns past the store read as zero
		send_request(make_req(tcb_pkg::OP_READ, 8'h00, 6'd0, 7'd127));
		send_request(make_req(tcb_pkg::OP_READ, 8'h00, 6'd0, 7'd120));
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_NEWLINE, 6'd0, 7'd0));
		// erase at column zero and a tick short of the period: both silent
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_BACKSPACE, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_TICK, 8'hFF, 6'd63, 7'd127));
		send_request(make_req(tcb_pkg::OP_BAR_ON, 8'h00, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_BAR_OFF, 8'h00, 6'd0, 7'd0));
		send_request(make_req(3'd6, 8'h41, 6'd1, 7'd1));
		send_request(make_req(3'd7, 8'h42, 6'd2, 7'd2));
		send_request(make_req(tcb_pkg::OP_CLEAR, 8'h00, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_READ, 8'h00, 6'd0, 7'd1));
	endtask

	// Bar toggling at the shortest periods, a zero period and the longest one.
	task automatic test_blink();
		set_geometry(16'd80, 16'd48, 16'd1);
		repeat (4) send_request(make_req(tcb_pkg::OP_TICK, 8'h00, 6'd0, 7'd0));
		set_geometry(16'd80, 16'd48, 16'd0);
		repeat (3) send_request(make_req(tcb_pkg::OP_TICK, 8'h00, 6'd0, 7'd0));
		set_geometry(16'd80, 16'd48, 16'd2);
		repeat (5) send_request(make_req(tcb_pkg::OP_TICK, 8'h00, 6'd0, 7'd0));
		set_geometry(16'd80, 16'd48, 16'd65535);
		repeat (3) send_request(make_req(tcb_pkg::OP_TICK, 8'h00, 6'd0, 7'd0));
	endtask

	// Wrapping: zero width, one column, upper data bits ignored, clipped width.
	task automatic test_wrap();
		set_geometry(16'd0, 16'd48, 16'd1);
		repeat (3) send_request(make_req(tcb_pkg::OP_PUT, random_glyph(), 6'd0, 7'd0));
		set_geometry(16'd1, 16'd48, 16'd1);
		repeat (3) send_request(make_req(tcb_pkg::OP_PUT, random_glyph(), 6'd0, 7'd0));
		set_geometry(16'hAB05, 16'd48, 16'd1);
		repeat (12) send_request(make_req(tcb_pkg::OP_PUT, random_glyph(), 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_BACKSPACE, 6'd0, 7'd0));
		// 127 columns act as the full store width
		set_geometry(16'd127, 16'd48, 16'd1);
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_NEWLINE, 6'd0, 7'd0));
		repeat (COLS + 3)
			send_request(make_req(tcb_pkg::OP_PUT, random_glyph(), 6'd0, 7'd0));
		// shrink the window with the cursor far right, then erase and write
		set_geometry(16'd120, 16'd48, 16'd1);
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_NEWLINE, 6'd0, 7'd0));
		repeat (COLS) send_request(make_req(tcb_pkg::OP_PUT, random_glyph(), 6'd0, 7'd0));
		set_geometry(16'd1, 16'd48, 16'd1);
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_BACKSPACE, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_PUT, random_glyph(), 6'd0, 7'd0));
	endtask

	// Scrolling past the last buffer row, window tracking for short, zero,
	// exact and tall windows, then reads of the shifted rows.
	task automatic test_scroll();
		set_geometry(16'd10, 16'd3, 16'd5);
		send_request(make_req(tcb_pkg::OP_CLEAR, 8'h00, 6'd0, 7'd0));
		repeat (ROWS + 6) begin
			send_request(make_req(tcb_pkg::OP_PUT, random_glyph(), 6'd0, 7'd0));
			send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_NEWLINE, 6'd0, 7'd0));
		end
		for (int r = ROWS - 6; r < ROWS; r++)
			send_request(make_req(tcb_pkg::OP_READ, 8'h00, 6'(r), 7'd0));
		set_geometry(16'd10, 16'd0, 16'd5);
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_NEWLINE, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_PUT, random_glyph(), 6'd0, 7'd0));
		set_geometry(16'd10, 16'd127, 16'd5);
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_NEWLINE, 6'd0, 7'd0));
		set_geometry(16'd10, 16'd64, 16'd5);
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_NEWLINE, 6'd0, 7'd0));
		set_geometry(16'd10, 16'd63, 16'd5);
		send_request(make_req(tcb_pkg::OP_PUT, tcb_pkg::CH_NEWLINE, 6'd0, 7'd0));
		send_request(make_req(tcb_pkg::OP_READ, 8'h00, 6'd62, 7'd0));
	endtask

	// Random traffic over a spread of settings. State carries over between
	// phases, so rows pile up and scroll. Each setting change first drains
	// the console completely. One phase runs without any sender gaps.
	task automatic test_random();
		logic [15:0] geo [8][3] = '{
			'{16'd80,  16'd48,  16'd3000},
			'{16'd1,   16'd1,   16'd1},
			'{16'd120, 16'd64,  16'd2},
			'{16'd127, 16'd127, 16'd65535},
			'{16'd7,   16'd5,   16'd3},
			'{16'd0,   16'd0,   16'd0},
			'{16'd20,  16'd10,  16'd7},
			'{16'd3,   16'd63,  16'd1}
		};
		tcb_pkg::req_t r;
		int            done;
		for (int p = 0; p < 8; p++) begin
			set_geometry(geo[p][0], geo[p][1], geo[p][2]);
			idle_enable = (p != 2);
			done = 0;
			while (done < 100) begin
				r = random_request();
				send_request(r);
				// unused opcodes are ignored and do not count
				if (r.opcode <= tcb_pkg::OP_BAR_OFF)
					done++;
			end
		end
		idle_enable = 1'b1;
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		shadow_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_blink();
		test_wrap();
		test_scroll();
		test_random();
		drain_console();
		if (error_count == 0) begin
			$display("text_console_buffer_top test passed");
		end else begin
			$display("text_console_buffer_top test failed");
		end
		$finish;
	end

endmodule

/* files.f */
src/tcb_pkg.sv
src/tcb_ram.sv
src/text_console_buffer_top.sv
bench/tb.sv
